// ===== sv/fpds_pkg.sv =====
// ----------------------------------------------------------------------------
// fpds_pkg: shared definitions for the fixed-point square root
// Field widths, parameter defaults, sequencer states and the control and
// status groups passed between the top level and the iteration core.
// ----------------------------------------------------------------------------
`default_nettype none

package fpds_pkg;

  localparam int FPDS_RAD_W     = 32;
  localparam int FPDS_ROOT_W    = 32;
  localparam int FPDS_FRAC_BITS = 16;
  localparam int FPDS_IN_BITS   = 32;

  typedef enum logic {
    SQ_IDLE,
    SQ_RUN
  } fpds_state_t;

  typedef struct packed {
    logic start;
    logic hold;
  } fpds_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fpds_stat_t;

endpackage

`default_nettype wire

// ===== sv/fpds_rad_if.sv =====
// ----------------------------------------------------------------------------
// fpds_rad_if: radicand channel
// Valid/ready channel that carries one unsigned radicand per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpds_rad_if;
  logic                           valid;
  logic                           ready;
  logic [fpds_pkg::FPDS_RAD_W-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

`default_nettype wire

// ===== sv/fpds_root_if.sv =====
// ----------------------------------------------------------------------------
// fpds_root_if: root channel
// Valid/ready channel that carries one fixed-point root per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpds_root_if;
  logic                            valid;
  logic                            ready;
  logic [fpds_pkg::FPDS_ROOT_W-1:0] root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

`default_nettype wire

// ===== sv/fpds_core.sv =====
// ----------------------------------------------------------------------------
// fpds_core: restoring square root iteration
// Radicand shifts out two bits a cycle, the root shifts in one bit a cycle,
// one trial subtract per cycle against the partial remainder, except while the last bit is held.
// ----------------------------------------------------------------------------
`default_nettype none

module fpds_core #(
  parameter int FRAC_BITS = fpds_pkg::FPDS_FRAC_BITS,
  parameter int IN_BITS   = fpds_pkg::FPDS_IN_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire fpds_pkg::fpds_ctrl_t          ctrl,
  input  wire logic [fpds_pkg::FPDS_RAD_W-1:0] radicand,
  output fpds_pkg::fpds_stat_t               stat,
  output logic [(IN_BITS+1)/2+FRAC_BITS-1:0] root_raw
);

  localparam int IN_PAIRS = (IN_BITS + 1) / 2;
  localparam int PAIRS    = IN_PAIRS + FRAC_BITS;
  localparam int RS_W     = 2 * IN_PAIRS;
  localparam int REM_W    = PAIRS + 3;
  localparam int CNT_W    = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  fpds_pkg::fpds_state_t state, state_next;

  logic [RS_W-1:0]  rad_sh, rad_sh_next;
  logic [REM_W-1:0] rem, rem_next;
  logic [PAIRS-1:0] q, q_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             done, done_next;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [REM_W:0]   diff;
  logic             fits;
  logic             last;
  logic             step;

  // one recurrence step
  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad_sh[RS_W-1 -: 2]};
    trial  = REM_W'({q, 2'b01});
    diff   = {1'b0, rem_sh} - {1'b0, trial};
    fits   = ~diff[REM_W];
    last   = (cnt == '0);
    // last bit waits while the output slot is still occupied
    step   = ~(last & ctrl.hold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpds_pkg::SQ_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rad_sh <= rad_sh_next;
    rem    <= rem_next;
    q      <= q_next;
    cnt    <= cnt_next;
  end

  always_comb begin
    state_next  = state;
    done_next   = 1'b0;
    rad_sh_next = rad_sh;
    rem_next    = rem;
    q_next      = q;
    cnt_next    = cnt;
    unique case (state)
      fpds_pkg::SQ_IDLE: begin
        if (ctrl.start) begin
          rad_sh_next = RS_W'(radicand[IN_BITS-1:0]);
          rem_next    = '0;
          q_next      = '0;
          cnt_next    = CNT_W'(PAIRS - 1);
          state_next  = fpds_pkg::SQ_RUN;
        end
      end
      fpds_pkg::SQ_RUN: begin
        if (step) begin
          rad_sh_next = rad_sh << 2;
          rem_next    = fits ? diff[REM_W-1:0] : rem_sh;
          q_next      = PAIRS'({q, fits});
          cnt_next    = cnt - CNT_W'(1);
          if (last) begin
            done_next  = 1'b1;
            state_next = fpds_pkg::SQ_IDLE;
          end
        end
      end
      default: state_next = fpds_pkg::SQ_IDLE;
    endcase
  end

  assign stat.busy = (state != fpds_pkg::SQ_IDLE);
  assign stat.done = done;
  assign root_raw  = q;

  a_done_after_run : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == fpds_pkg::SQ_RUN)
    else $error("root finished without a run");

  a_start_idle : assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> state == fpds_pkg::SQ_IDLE)
    else $error("start while an item is in progress");

  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    state == fpds_pkg::SQ_RUN |-> rem <= REM_W'({q, 1'b0}))
    else $error("partial remainder exceeds twice the root");

  a_hold_last : assert property (@(posedge clk) disable iff (rst)
    (state == fpds_pkg::SQ_RUN && cnt == '0 && ctrl.hold) |=>
      (state == fpds_pkg::SQ_RUN && !done))
    else $error("last bit completed while the output slot was full");

endmodule

`default_nettype wire

// ===== sv/fixed_point_digit_sqrt_top.sv =====
// ----------------------------------------------------------------------------
// fixed_point_digit_sqrt_top: truncated fixed-point square root
// Restoring bit-by-bit square root of an unsigned integer with FRAC_BITS
// fraction bits in the result, saturated to the 32-bit root field.
// ----------------------------------------------------------------------------
// One item at a time. An accepted radicand (low IN_BITS bits used) runs
// (IN_BITS+1)/2 + FRAC_BITS iterations in the core, one root bit per cycle
// (unless the last bit is held), set by the single shared trial subtractor;
// the root is loaded into the output register when the core flags done, and
// a radicand is taken only while the core is idle. The output register lets
// the next item start while a root waits; if it is still waiting when the
// next root's last bit is due, the core holds on that bit. Zero gives zero.
`default_nettype none

module fixed_point_digit_sqrt_top #(
  parameter int FRAC_BITS = fpds_pkg::FPDS_FRAC_BITS,
  parameter int IN_BITS   = fpds_pkg::FPDS_IN_BITS
) (
  input wire logic clk,
  input wire logic rst,
  fpds_rad_if.sink    operand,
  fpds_root_if.source result
);

  localparam int PAIRS  = (IN_BITS + 1) / 2 + FRAC_BITS;
  localparam int ROOT_W = fpds_pkg::FPDS_ROOT_W;
  localparam int EXT_W  = (PAIRS > ROOT_W) ? PAIRS : ROOT_W + 1;

  fpds_pkg::fpds_ctrl_t ctrl;
  fpds_pkg::fpds_stat_t stat;

  logic [PAIRS-1:0]  root_raw;
  logic [EXT_W-1:0]  root_ext;
  logic              sat;
  logic [ROOT_W-1:0] root_sat;

  logic              out_valid;
  logic [ROOT_W-1:0] out_root;

  assign operand.ready = ~stat.busy;
  assign ctrl.start    = operand.valid & ~stat.busy;
  assign ctrl.hold     = out_valid & ~result.ready;

  fpds_core #(
    .FRAC_BITS (FRAC_BITS),
    .IN_BITS   (IN_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .radicand (operand.radicand),
    .stat     (stat),
    .root_raw (root_raw)
  );

  // saturate roots that overflow the field
  always_comb begin
    root_ext = EXT_W'(root_raw);
    sat      = ((root_ext >> ROOT_W) != '0);
    root_sat = sat ? '1 : root_ext[ROOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.done) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_root <= root_sat;
    end
  end

  assign result.valid = out_valid;
  assign result.root  = out_root;

endmodule

`default_nettype wire
